// ===== rtl/dcre_pkg.sv =====
// Shared types, codes and helpers of the DShot channel refresh encoder.
package dcre_pkg;

    // Motor count and the width of a motor index into the state memory.
    localparam int MOTORS = 4;
    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [3:0] MOTOR_COUNT = 4'(MOTORS);
    localparam logic [MIDX_W-1:0] LAST_MOTOR = MIDX_W'(MOTORS - 1);

    // Lowest raw value that counts as throttle.
    localparam logic [10:0] THROTTLE_MIN = 11'd48;

    // Reset values of the configuration registers.
    localparam logic [15:0] PRIME_RESET = 16'd200;
    localparam logic [15:0] REARM_RESET = 16'd200;

    // Configuration register indexes.
    localparam logic CFG_PRIME = 1'b0;
    localparam logic CFG_REARM = 1'b1;

    // Request codes.
    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_ENABLE  = 3'd1;
    localparam logic [2:0] REQ_DISABLE = 3'd2;
    localparam logic [2:0] REQ_REFRESH = 3'd3;
    localparam logic [2:0] REQ_DONE    = 3'd4;

    // Result kinds.
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DISABLED  = 2'd1;
    localparam logic [1:0] ST_BAD_MOTOR = 2'd2;

    // Refresh action codes.
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SILENCE = 2'd1;
    localparam logic [1:0] ACT_SENT    = 2'd2;
    localparam logic [1:0] ACT_BUSY    = 2'd3;

    // Read-modify-write operation applied to one motor entry.
    typedef enum logic [2:0] {
        OP_REFRESH,
        OP_WRITE,
        OP_DONE,
        OP_ENABLE,
        OP_DISABLE,
        OP_WIPE
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_REPLY
    } t_state;

    // One entry of the per-motor state memory.
    typedef struct packed {
        logic [10:0] value;
        logic        telem;
        logic        live;
        logic        rearm;
        logic [31:0] rearm_begin;
        logic        busy;
    } t_motor_entry;

    localparam int ENTRY_W = $bits(t_motor_entry);

    // Control handed from the sequencer to the entry update logic.
    typedef struct packed {
        t_op         op;
        logic        prime;
        logic [10:0] value;
        logic        telem;
    } t_upd_ctl;

    // DShot frame: value, telemetry bit, then the XOR of the three nibbles.
    function automatic logic [15:0] make_frame(logic [10:0] value, logic telem);
        logic [11:0] pkt;
        logic [3:0]  crc;
        pkt = {value, telem};
        crc = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];
        return {pkt, crc};
    endfunction

endpackage

// ===== rtl/dcre_state_ram.sv =====
// Synchronous single-write, single-read memory with registered read data.
module dcre_state_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dcre_motor_update.sv =====
// Next value of one motor entry and its refresh action and frame.
module dcre_motor_update (
    input  dcre_pkg::t_upd_ctl     i_ctl,
    input  dcre_pkg::t_motor_entry i_entry,
    input  logic [31:0]            i_tick,
    input  logic [15:0]            i_rearm_ticks,
    output dcre_pkg::t_motor_entry o_entry,
    output logic [1:0]             o_action,
    output logic [15:0]            o_frame
);
    import dcre_pkg::*;

    t_motor_entry ref_entry;
    logic         want;
    logic [10:0]  eff_value;
    logic         eff_telem;
    logic [31:0]  rearm_age;
    logic [1:0]   ref_action;
    logic [15:0]  ref_frame;

    // Refresh: silence an unused line, otherwise send a frame unless busy.
    // The frame is zero inside the prime window and the motor's rearm window.
    always_comb begin
        ref_entry  = i_entry;
        ref_action = ACT_NONE;
        ref_frame  = '0;
        want       = (i_entry.value != '0) || i_entry.telem;
        eff_value  = i_ctl.prime ? '0 : i_entry.value;
        eff_telem  = i_ctl.prime ? 1'b0 : i_entry.telem;
        rearm_age  = '0;
        if (!want) begin
            ref_entry.rearm = 1'b0;
            if (i_entry.busy) begin
                ref_action = ACT_BUSY;
            end else if (i_entry.live) begin
                ref_entry.live = 1'b0;
                ref_action     = ACT_SILENCE;
            end
        end else begin
            if (!i_entry.live) begin
                ref_entry.live = 1'b1;
                ref_entry.busy = 1'b0;
                if (eff_value >= THROTTLE_MIN) begin
                    ref_entry.rearm       = 1'b1;
                    ref_entry.rearm_begin = i_tick;
                end
            end
            rearm_age = i_tick - ref_entry.rearm_begin;
            if (ref_entry.rearm) begin
                if (rearm_age < {16'd0, i_rearm_ticks}) begin
                    eff_value = '0;
                    eff_telem = 1'b0;
                end else begin
                    ref_entry.rearm = 1'b0;
                end
            end
            if (ref_entry.busy) begin
                ref_action = ACT_BUSY;
            end else begin
                ref_frame      = make_frame(eff_value, eff_telem);
                ref_entry.busy = 1'b1;
                ref_action     = ACT_SENT;
            end
        end
    end

    // Select the modification by operation.
    always_comb begin
        o_entry  = i_entry;
        o_action = ACT_NONE;
        o_frame  = '0;
        unique case (i_ctl.op)
            OP_REFRESH: begin
                o_entry  = ref_entry;
                o_action = ref_action;
                o_frame  = ref_frame;
            end
            OP_WRITE: begin
                o_entry.value = i_ctl.value;
                o_entry.telem = i_ctl.telem;
            end
            OP_DONE: begin
                o_entry.busy = 1'b0;
            end
            OP_ENABLE: begin
                o_entry = '0;
            end
            OP_DISABLE: begin
                o_entry.value = '0;
                o_entry.live  = 1'b0;
                o_entry.rearm = 1'b0;
                o_entry.busy  = 1'b0;
            end
            OP_WIPE: begin
                o_entry = '0;
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule

// ===== rtl/dshot_channel_refresh_encoder_unit.sv =====
// Top level of the DShot channel refresh encoder: sequencer, globals and output register.
// Each input beat gets one status beat, except an enabled refresh tick, which gives one
// action beat per motor (motor 0 first, last flag on the final one). Per-motor state sits
// in a small memory and is handled by read-modify-write, a read state then a modify state
// per motor; the output side can stall a refresh in its modify state and any status reply.
// After reset the block clears the memory one motor at a time before it takes the first
// beat; configuration writes are taken at any time.
module dshot_channel_refresh_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [2:0]  i_motor,
    input  logic [10:0] i_motor_value,
    input  logic        i_telem_bit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [1:0]  o_status,
    output logic [2:0]  o_channel,
    output logic [1:0]  o_action,
    output logic [15:0] o_frame_word,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dcre_pkg::*;

    t_state              r_state, n_state;
    logic [MIDX_W-1:0]   r_idx;
    t_op                 r_op;
    logic                r_single;
    logic [10:0]         r_val;
    logic                r_tel;
    logic [1:0]          r_status;
    logic                r_enabled;
    logic [31:0]         r_enable_time;
    logic [31:0]         r_tick;
    logic [15:0]         r_prime_ticks;
    logic [15:0]         r_rearm_ticks;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [1:0]          r_out_status;
    logic [2:0]          r_out_channel;
    logic [1:0]          r_out_action;
    logic [15:0]         r_out_frame;
    logic                r_out_last;

    logic                in_accept;
    logic                out_free;
    logic                bad_motor;
    logic                prime;
    logic                idx_last;
    logic                ram_re;
    logic                ram_we;
    logic                push;
    logic                push_refresh;
    t_upd_ctl            upd_ctl;
    t_motor_entry        rd_entry;
    t_motor_entry        wr_entry;
    logic [1:0]          upd_action;
    logic [15:0]         upd_frame;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign bad_motor = {1'b0, i_motor} >= MOTOR_COUNT;
    assign prime     = (r_tick - r_enable_time) < {16'd0, r_prime_ticks};
    assign idx_last  = (r_idx == LAST_MOTOR);
    assign upd_ctl   = '{op: r_op, prime: prime, value: r_val, telem: r_tel};

    // Per-motor state memory.
    dcre_state_ram #(
        .DEPTH (MOTORS),
        .WIDTH (ENTRY_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    // Entry modification.
    dcre_motor_update u_motor_update (
        .i_ctl         (upd_ctl),
        .i_entry       (rd_entry),
        .i_tick        (r_tick),
        .i_rearm_ticks (r_rearm_ticks),
        .o_entry       (wr_entry),
        .o_action      (upd_action),
        .o_frame       (upd_frame)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_ticks <= PRIME_RESET;
            r_rearm_ticks <= REARM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRIME: r_prime_ticks <= i_cfg_data;
                CFG_REARM: r_rearm_ticks <= i_cfg_data;
                default:   r_prime_ticks <= r_prime_ticks;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WIPE: begin
                if (idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) begin
                    priority case (i_req_type)
                        REQ_WRITE:   n_state = (bad_motor || !r_enabled) ? S_REPLY : S_READ;
                        REQ_ENABLE:  n_state = S_READ;
                        REQ_DISABLE: n_state = S_READ;
                        REQ_REFRESH: n_state = r_enabled ? S_READ : S_REPLY;
                        REQ_DONE:    n_state = bad_motor ? S_REPLY : S_READ;
                        default:     n_state = S_REPLY;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                if (r_op == OP_REFRESH) begin
                    if (out_free) n_state = idx_last ? S_IDLE : S_READ;
                end else begin
                    n_state = (r_single || idx_last) ? S_REPLY : S_READ;
                end
            end
            S_REPLY: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        ram_re       = (r_state == S_READ);
        ram_we       = 1'b0;
        push         = 1'b0;
        push_refresh = 1'b0;
        unique case (r_state)
            S_WIPE: begin
                ram_we = 1'b1;
            end
            S_MODIFY: begin
                if (r_op == OP_REFRESH) begin
                    ram_we       = out_free;
                    push         = out_free;
                    push_refresh = out_free;
                end else begin
                    ram_we = 1'b1;
                end
            end
            S_REPLY: begin
                push = out_free;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers: state, motor index, operation and global state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_WIPE;
            r_idx         <= '0;
            r_op          <= OP_WIPE;
            r_single      <= 1'b0;
            r_status      <= ST_OK;
            r_enabled     <= 1'b0;
            r_enable_time <= '0;
            r_tick        <= '0;
        end else begin
            r_state <= n_state;
            if (ram_we && !idx_last && (r_state == S_WIPE || !r_single)) begin
                r_idx <= r_idx + MIDX_W'(1);
            end
            if (in_accept) begin
                priority case (i_req_type)
                    REQ_WRITE: begin
                        r_op     <= OP_WRITE;
                        r_single <= 1'b1;
                        r_idx    <= i_motor[MIDX_W-1:0];
                        if (bad_motor) begin
                            r_status <= ST_BAD_MOTOR;
                        end else if (!r_enabled) begin
                            r_status <= ST_DISABLED;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                    REQ_ENABLE: begin
                        r_op          <= OP_ENABLE;
                        r_single      <= 1'b0;
                        r_idx         <= '0;
                        r_status      <= ST_OK;
                        r_enabled     <= 1'b1;
                        r_enable_time <= r_tick;
                    end
                    REQ_DISABLE: begin
                        r_op      <= OP_DISABLE;
                        r_single  <= 1'b0;
                        r_idx     <= '0;
                        r_status  <= ST_OK;
                        r_enabled <= 1'b0;
                    end
                    REQ_REFRESH: begin
                        r_op     <= OP_REFRESH;
                        r_single <= 1'b0;
                        r_idx    <= '0;
                        if (!r_enabled) begin
                            r_status <= ST_DISABLED;
                            r_tick   <= r_tick + 32'd1;
                        end else begin
                            r_status <= ST_OK;
                        end
                    end
                    REQ_DONE: begin
                        r_op     <= OP_DONE;
                        r_single <= 1'b1;
                        r_idx    <= i_motor[MIDX_W-1:0];
                        r_status <= bad_motor ? ST_BAD_MOTOR : ST_OK;
                    end
                    default: begin
                        r_op     <= OP_DONE;
                        r_single <= 1'b0;
                        r_idx    <= '0;
                        r_status <= ST_OK;
                    end
                endcase
            end
            // The tick clock advances when a refresh ends or is taken while disabled.
            if (push_refresh && idx_last) begin
                r_tick <= r_tick + 32'd1;
            end
        end
    end

    // Input payload held for the entry update.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_val <= i_motor_value;
            r_tel <= i_telem_bit;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload: a refresh action or a status reply.
    always_ff @(posedge i_clk) begin
        if (push) begin
            if (push_refresh) begin
                r_out_kind    <= KIND_REFRESH;
                r_out_status  <= ST_OK;
                r_out_channel <= 3'(r_idx);
                r_out_action  <= upd_action;
                r_out_frame   <= upd_frame;
                r_out_last    <= idx_last;
            end else begin
                r_out_kind    <= KIND_STATUS;
                r_out_status  <= r_status;
                r_out_channel <= '0;
                r_out_action  <= ACT_NONE;
                r_out_frame   <= '0;
                r_out_last    <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_status      = r_out_status;
    assign o_channel     = r_out_channel;
    assign o_action      = r_out_action;
    assign o_frame_word  = r_out_frame;
    assign o_last        = r_out_last;

    // The last refresh beat of a tick always concerns the highest motor.
    a_refresh_last_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_REFRESH && o_last)
            |-> (o_channel == 3'(LAST_MOTOR)))
        else $error("refresh beat marked last on a lower motor");

    // A status reply closes its request and carries no action.
    a_status_reply_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_STATUS)
            |-> (o_last && o_channel == 3'd0 && o_action == ACT_NONE))
        else $error("malformed status reply");

    // Only a sent frame carries a nonzero frame word.
    a_frame_only_when_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != ACT_SENT) |-> (o_frame_word == 16'd0))
        else $error("frame word set without a sent frame");

    // The tick clock only ever steps by one.
    a_tick_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_tick != $past(r_tick)))
            |-> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick clock jumped");

endmodule

// ===== verif/dcre_checker.sv =====
// Checker for the DShot channel refresh encoder: motor state predictor and result scoreboard.
module dcre_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [2:0]  i_motor,
    input  logic [10:0] i_motor_value,
    input  logic        i_telem_bit,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_result_kind,
    input  logic [1:0]  i_status,
    input  logic [2:0]  i_channel,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_frame_word,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import dcre_pkg::*;

    // One result beat as the block should send it.
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [2:0]  channel;
        logic [1:0]  action;
        logic [15:0] frame;
        logic        last;
    } t_reply;

    // Predicted per-motor state.
    logic [10:0] mot_value   [MOTORS];
    logic        mot_telem   [MOTORS];
    logic        mot_live    [MOTORS];
    logic        mot_rearm   [MOTORS];
    logic [31:0] mot_rearm_at[MOTORS];
    logic        mot_busy    [MOTORS];

    // Predicted global state and register copies.
    logic        out_on;
    logic [31:0] on_stamp;
    logic [31:0] ticks;
    logic [15:0] prime_len;
    logic [15:0] rearm_len;

    t_reply replies_due[$];
    int     fail_total = 0;

    assign o_fail_count = fail_total;

    // Frame word: value and telemetry bit, then the XOR of the packet's three nibbles.
    function automatic logic [15:0] dshot_word(logic [10:0] value, logic telem);
        logic [11:0] pkt;
        logic [11:0] folded;
        pkt    = {value, telem};
        folded = pkt ^ (pkt >> 4) ^ (pkt >> 8);
        return {pkt, folded[3:0]};
    endfunction

    function automatic void push_status(logic [1:0] st);
        replies_due.push_back('{KIND_STATUS, st, 3'd0, ACT_NONE, 16'd0, 1'b1});
    endfunction

    // Clears the motors; a disable keeps the telemetry bits.
    function automatic void clear_motors(logic keep_telem);
        for (int m = 0; m < MOTORS; m++) begin
            mot_value[m] = '0;
            if (!keep_telem) begin
                mot_telem[m] = 1'b0;
            end
            mot_live[m]  = 1'b0;
            mot_rearm[m] = 1'b0;
            mot_busy[m]  = 1'b0;
        end
    endfunction

    function automatic void reset_state();
        clear_motors(1'b0);
        for (int m = 0; m < MOTORS; m++) begin
            mot_rearm_at[m] = '0;
        end
        out_on    = 1'b0;
        on_stamp  = '0;
        ticks     = '0;
        prime_len = PRIME_RESET;
        rearm_len = REARM_RESET;
        replies_due.delete();
    endfunction

    // One refresh tick while output is on: one action per motor, in motor order.
    function automatic void refresh_motors();
        logic [31:0] age;
        logic        in_prime;
        logic [10:0] v;
        logic        t;
        logic [1:0]  act;
        logic [15:0] fw;
        age      = ticks - on_stamp;
        in_prime = age < {16'd0, prime_len};
        for (int m = 0; m < MOTORS; m++) begin
            v  = mot_value[m];
            t  = mot_telem[m];
            fw = '0;
            if (v == '0 && !t) begin
                // Nothing to send: the line is silenced once no burst is in flight.
                mot_rearm[m] = 1'b0;
                if (mot_busy[m]) begin
                    act = ACT_BUSY;
                end else if (mot_live[m]) begin
                    mot_live[m] = 1'b0;
                    act = ACT_SILENCE;
                end else begin
                    act = ACT_NONE;
                end
            end else begin
                if (in_prime) begin
                    v = '0;
                    t = 1'b0;
                end
                // A line that goes live with throttle opens its rearm window.
                if (!mot_live[m]) begin
                    mot_live[m] = 1'b1;
                    mot_busy[m] = 1'b0;
                    if (v >= THROTTLE_MIN) begin
                        mot_rearm[m]    = 1'b1;
                        mot_rearm_at[m] = ticks;
                    end
                end
                if (mot_rearm[m]) begin
                    age = ticks - mot_rearm_at[m];
                    if (age < {16'd0, rearm_len}) begin
                        v = '0;
                        t = 1'b0;
                    end else begin
                        mot_rearm[m] = 1'b0;
                    end
                end
                if (mot_busy[m]) begin
                    act = ACT_BUSY;
                end else begin
                    fw          = dshot_word(v, t);
                    mot_busy[m] = 1'b1;
                    act         = ACT_SENT;
                end
            end
            replies_due.push_back('{KIND_REFRESH, ST_OK, 3'(m), act, fw, (m == MOTORS - 1)});
        end
    endfunction

    // Updates the predicted state for one accepted request and queues its results.
    function automatic void forecast_replies(logic [2:0] req, logic [2:0] mot,
                                             logic [10:0] val, logic tel);
        case (req)
            REQ_WRITE: begin
                if (mot >= MOTORS) begin
                    push_status(ST_BAD_MOTOR);
                end else if (!out_on) begin
                    push_status(ST_DISABLED);
                end else begin
                    mot_value[mot[MIDX_W-1:0]] = val;
                    mot_telem[mot[MIDX_W-1:0]] = tel;
                    push_status(ST_OK);
                end
            end
            REQ_ENABLE: begin
                clear_motors(1'b0);
                on_stamp = ticks;
                out_on   = 1'b1;
                push_status(ST_OK);
            end
            REQ_DISABLE: begin
                out_on = 1'b0;
                clear_motors(1'b1);
                push_status(ST_OK);
            end
            REQ_DONE: begin
                if (mot >= MOTORS) begin
                    push_status(ST_BAD_MOTOR);
                end else begin
                    mot_busy[mot[MIDX_W-1:0]] = 1'b0;
                    push_status(ST_OK);
                end
            end
            REQ_REFRESH: begin
                if (out_on) begin
                    refresh_motors();
                end else begin
                    push_status(ST_DISABLED);
                end
                ticks = ticks + 32'd1;
            end
            default: begin
                push_status(ST_OK);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function automatic void compare_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            $error("unexpected result beat: kind %0d status %0d channel %0d action %0d",
                   i_result_kind, i_status, i_channel, i_action);
            fail_total++;
            return;
        end
        want = replies_due.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(i_result_kind));
        check_field("status", 16'(want.status), 16'(i_status));
        check_field("channel", 16'(want.channel), 16'(i_channel));
        check_field("action", 16'(want.action), 16'(i_action));
        check_field("frame_word", want.frame, i_frame_word);
        check_field("last", 16'(want.last), 16'(i_last));
    endfunction

    // Requests are predicted before results are compared; a result never leaves in the
    // cycle its request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRIME) begin
                    prime_len = i_cfg_data;
                end else begin
                    rearm_len = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                forecast_replies(i_req_type, i_motor, i_motor_value, i_telem_bit);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_reply();
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the DShot channel refresh encoder: stimulus, handshake idling and verdict.
module tb;
    import dcre_pkg::*;

    localparam int CLOCK_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 + 2 * MOTORS;
    localparam int PHASE_BEATS  = 72;
    localparam int PHASES       = 6;

    // Request codes the block treats as no-ops.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_req_type;
    logic [2:0]  i_motor;
    logic [10:0] i_motor_value;
    logic        i_telem_bit;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_result_kind;
    logic [1:0]  o_status;
    logic [2:0]  o_channel;
    logic [1:0]  o_action;
    logic [15:0] o_frame_word;
    logic        o_last;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    int          fail_count;
    int          pending_count;
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 47;
    int unsigned cycle_count   = 0;
    logic        powered       = 1'b0;

    dshot_channel_refresh_encoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_motor       (i_motor),
        .i_motor_value (i_motor_value),
        .i_telem_bit   (i_telem_bit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .o_channel     (o_channel),
        .o_action      (o_action),
        .o_frame_word  (o_frame_word),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dcre_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_motor       (i_motor),
        .i_motor_value (i_motor_value),
        .i_telem_bit   (i_telem_bit),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_result_kind (o_result_kind),
        .i_status      (o_status),
        .i_channel     (o_channel),
        .i_action      (o_action),
        .i_frame_word  (o_frame_word),
        .i_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one request beat, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_beat(input logic [2:0] req, input logic [2:0] mot,
                             input logic [10:0] val, input logic tel);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_motor       <= mot;
        i_motor_value <= val;
        i_telem_bit   <= tel;
        do @(posedge i_clk); while (o_in_stall);
        if (req == REQ_ENABLE) begin
            powered = 1'b1;
        end else if (req == REQ_DISABLE) begin
            powered = 1'b0;
        end
    endtask

    // Waits until every expected result has come, then lets the block go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] prime, input logic [15:0] rearm);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PRIME;
        i_cfg_data  <= prime;
        @(posedge i_clk);
        i_cfg_index <= CFG_REARM;
        i_cfg_data  <= rearm;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random request; mostly well-formed traffic on live motors, some noise.
    task automatic random_beat();
        int unsigned pick;
        int unsigned shade;
        logic [2:0]  req;
        logic [2:0]  mot;
        logic [10:0] val;
        logic        tel;
        pick  = $urandom_range(0, 99);
        shade = $urandom_range(0, 99);
        mot   = 3'($urandom_range(0, MOTORS - 1));
        val   = 11'($urandom);
        tel   = 1'($urandom);
        if (!powered && pick < 60) begin
            req = REQ_ENABLE;
        end else if (pick < 30) begin
            req = REQ_REFRESH;
        end else if (pick < 57) begin
            req = REQ_WRITE;
            if (shade < 20) begin
                val = '0;
                tel = 1'b0;
            end else if (shade < 35) begin
                val = 11'($urandom_range(1, THROTTLE_MIN - 1));
            end else if (shade < 85) begin
                val = 11'($urandom_range(THROTTLE_MIN, 2047));
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        val = '0;
                        tel = 1'b1;
                    end
                    1: val = '1;
                    2: val = THROTTLE_MIN;
                    default: val = THROTTLE_MIN - 11'd1;
                endcase
            end
        end else if (pick < 80) begin
            req = REQ_DONE;
        end else if (pick < 85) begin
            req = (shade < 50) ? REQ_WRITE : REQ_DONE;
            mot = 3'($urandom_range(MOTORS, 7));
        end else if (pick < 88) begin
            req = REQ_DISABLE;
        end else if (pick < 92) begin
            req = REQ_ENABLE;
        end else if (pick < 96) begin
            req = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            mot = 3'($urandom);
        end else begin
            req = REQ_REFRESH;
            mot = 3'($urandom);
        end
        send_beat(req, mot, val, tel);
    endtask

    initial begin
        logic [15:0] prime;
        logic [15:0] rearm;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_WRITE;
        i_motor       = '0;
        i_motor_value = '0;
        i_telem_bit   = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PRIME;
        i_cfg_data    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset register values: status paths first, then a
        // short enabled sequence inside the prime window.
        send_beat(REQ_REFRESH, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_WRITE, 3'd0, 11'd2047, 1'b1);
        send_beat(REQ_WRITE, 3'd7, 11'd5, 1'b0);
        send_beat(REQ_DONE, 3'(MOTORS), 11'd0, 1'b0);
        send_beat(REQ_DONE, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_SPARE_FIRST, 3'd7, 11'd2047, 1'b1);
        send_beat(REQ_SPARE_LAST, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_DISABLE, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_ENABLE, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_ENABLE, 3'd1, 11'd0, 1'b0);
        send_beat(REQ_WRITE, 3'd0, 11'd2047, 1'b1);
        send_beat(REQ_WRITE, 3'd1, THROTTLE_MIN, 1'b0);
        send_beat(REQ_WRITE, 3'd2, THROTTLE_MIN - 11'd1, 1'b1);
        send_beat(REQ_WRITE, 3'd3, 11'd0, 1'b0);
        send_beat(REQ_REFRESH, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_REFRESH, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_DONE, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_DONE, 3'd1, 11'd0, 1'b0);
        send_beat(REQ_WRITE, 3'd2, 11'd0, 1'b0);
        send_beat(REQ_REFRESH, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_DISABLE, 3'd0, 11'd0, 1'b0);
        send_beat(REQ_REFRESH, 3'd0, 11'd0, 1'b0);
        settle();

        // Random phases, each under its own register setting; the idling pattern changes every two phases.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    prime = 16'd0;
                    rearm = 16'd0;
                end
                1: begin
                    prime = 16'd0;
                    rearm = 16'd4;
                end
                2: begin
                    prime = 16'd3;
                    rearm = 16'd6;
                end
                3: begin
                    prime = 16'hFFFF;
                    rearm = 16'd2;
                end
                4: begin
                    prime = 16'd1;
                    rearm = 16'hFFFF;
                end
                default: begin
                    prime = 16'($urandom_range(0, 9));
                    rearm = 16'($urandom_range(0, 9));
                end
            endcase
            if (ph < 2) begin
                send_idle_pct = 25;
                recv_idle_pct = 47;
            end else if (ph < 4) begin
                send_idle_pct = 47;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            program_regs(prime, rearm);
            send_beat(REQ_ENABLE, 3'($urandom), 11'($urandom), 1'($urandom));
            repeat (PHASE_BEATS) random_beat();
            settle();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== dshot_channel_refresh_encoder_unit.f =====
rtl/dcre_pkg.sv
rtl/dcre_state_ram.sv
rtl/dcre_motor_update.sv
rtl/dshot_channel_refresh_encoder_unit.sv
verif/dcre_checker.sv
verif/tb.sv
